[design/mbm_pkg.sv]
`timescale 1ns / 1ps

package mbm_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CNT_W  = 31;
  localparam int MEAN_W = 32;
  localparam int M2_W   = 63;
  localparam int MXY_W  = 64;

  localparam logic [M2_W-1:0] M2_MAX = {M2_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0]         part_count;
    logic signed [MEAN_W-1:0] part_mean_x;
    logic signed [MEAN_W-1:0] part_mean_y;
    logic [M2_W-1:0]          part_m2_x;
    logic [M2_W-1:0]          part_m2_y;
    logic signed [MXY_W-1:0]  part_m_xy;
    logic                     last_part;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]         total_count;
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic [M2_W-1:0]          m2_x;
    logic [M2_W-1:0]          m2_y;
    logic signed [MXY_W-1:0]  m_xy;
    logic                     overflow;
  } out_item_t;

endpackage

[design/mbm_if.sv]
`timescale 1ns / 1ps

interface mbm_in_if;
  logic              valid;
  logic              ready;
  mbm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mbm_out_if;
  logic               valid;
  logic               ready;
  mbm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/mbm_div.sv]
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module mbm_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         busy,
  output logic [127:0] quo
);

  logic [127:0] nq_r;
  logic [63:0]  rem_r;
  logic [63:0]  den_r;
  logic [6:0]   cnt_r;
  logic         busy_r;

  logic [64:0]  rem_sh;
  logic         ge;

  assign rem_sh = {rem_r, nq_r[127]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd127;
      nq_r   <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      rem_r <= ge ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
      nq_r  <= {nq_r[126:0], ge};
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = nq_r;

endmodule

[design/merge_bivariate_moments_top.sv]
`timescale 1ns / 1ps
// A partial is accepted only in the idle state, so a new partial is not taken until the last one is merged.
// Each partial runs five divisions on the shared bit-serial divider, with the shared 32x32
// multiplier used around them.
// A partial that leaves the total count at zero skips the arithmetic and goes straight to S_FIN.
// A last partial also waits while the previous result has not been transferred.
// Reset (synchronous, active low) zeroes the aggregate and empties the output register.
module merge_bivariate_moments_top (
  input  logic clk,
  input  logic rst_n,
  mbm_in_if.sink    in_ch,
  mbm_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_UU, S_PP, S_DSTART, S_DWAIT, S_TERM, S_MMUL, S_MEAN, S_FIN
  } state_t;

  typedef enum logic [2:0] {T_XX, T_YY, T_XY, T_MX, T_MY} term_t;

  state_t state_r;
  term_t  t_r;
  logic [1:0] pc_r;

  logic [30:0]  na_r, nb_r;
  logic [31:0]  n_r;
  logic [31:0]  adx_r, ady_r;
  logic         sx_r, sy_r;
  logic [62:0]  pm2x_r, pm2y_r;
  logic [63:0]  pmxy_r;
  logic         last_r;
  logic [61:0]  prod_r;
  logic [63:0]  uu_r;
  logic [127:0] acc_r;

  logic [30:0] acc_count_r;
  logic [31:0] acc_mean_x_r, acc_mean_y_r;
  logic [62:0] acc_m2_x_r, acc_m2_y_r;
  logic [63:0] acc_m_xy_r;
  logic        acc_overflow_r;

  logic                out_valid_r;
  mbm_pkg::out_item_t  out_data_r;

  logic signed [32:0] dx, dy;
  logic [31:0]  n_in;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  product;
  logic [1:0]   pw;
  logic         div_start, div_busy;
  logic [127:0] div_quo;
  logic [63:0]  div_den;
  logic         neg;
  logic signed [128:0] term;
  logic signed [129:0] sum;
  logic [31:0]  q32, mean_new;
  logic [30:0]  cnt_fin;
  logic         ovf_fin;

  assign dx   = 33'($signed(in_ch.data.part_mean_x)) - 33'($signed(acc_mean_x_r));
  assign dy   = 33'($signed(in_ch.data.part_mean_y)) - 33'($signed(acc_mean_y_r));
  assign n_in = {1'b0, acc_count_r} + {1'b0, in_ch.data.part_count};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PROD: begin
        mul_a = {1'b0, na_r};
        mul_b = {1'b0, nb_r};
      end
      S_UU: begin
        mul_a = (t_r == T_YY) ? ady_r : adx_r;
        mul_b = (t_r == T_XX) ? adx_r : ady_r;
      end
      S_PP: begin
        mul_a = pc_r[1] ? {2'b0, prod_r[61:32]} : prod_r[31:0];
        mul_b = pc_r[0] ? uu_r[63:32] : uu_r[31:0];
      end
      S_MMUL: begin
        mul_a = {1'b0, nb_r};
        mul_b = (t_r == T_MX) ? adx_r : ady_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign pw      = {1'b0, pc_r[1]} + {1'b0, pc_r[0]};

  assign div_start = (state_r == S_DSTART);
  assign div_den   = (t_r == T_MX || t_r == T_MY) ? 64'(n_r)
                                                 : (64'(n_r) << mbm_pkg::FRAC_BITS);

  mbm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_comb begin
    neg = 1'b0;
    sum = '0;
    unique case (t_r)
      T_XX: sum = 130'($signed({1'b0, acc_m2_x_r})) + 130'($signed({1'b0, pm2x_r}));
      T_YY: sum = 130'($signed({1'b0, acc_m2_y_r})) + 130'($signed({1'b0, pm2y_r}));
      T_XY: begin
        neg = sx_r ^ sy_r;
        sum = 130'($signed(acc_m_xy_r)) + 130'($signed(pmxy_r));
      end
      T_MX: neg = sx_r;
      T_MY: neg = sy_r;
      default: neg = 1'b0;
    endcase
    term = neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    sum  = sum + 130'(term);
  end

  assign q32      = neg ? -div_quo[31:0] : div_quo[31:0];
  assign mean_new = ((t_r == T_MX) ? acc_mean_x_r : acc_mean_y_r) + q32;
  assign cnt_fin  = n_r[31] ? {31{1'b1}} : n_r[30:0];
  assign ovf_fin  = acc_overflow_r | n_r[31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      t_r            <= T_XX;
      pc_r           <= '0;
      acc_count_r    <= '0;
      acc_mean_x_r   <= '0;
      acc_mean_y_r   <= '0;
      acc_m2_x_r     <= '0;
      acc_m2_y_r     <= '0;
      acc_m_xy_r     <= '0;
      acc_overflow_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !(state_r == S_FIN && last_r)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            na_r   <= acc_count_r;
            nb_r   <= in_ch.data.part_count;
            n_r    <= n_in;
            adx_r  <= dx[32] ? 32'(-dx) : dx[31:0];
            ady_r  <= dy[32] ? 32'(-dy) : dy[31:0];
            sx_r   <= dx[32];
            sy_r   <= dy[32];
            pm2x_r <= in_ch.data.part_m2_x;
            pm2y_r <= in_ch.data.part_m2_y;
            pmxy_r <= in_ch.data.part_m_xy;
            last_r <= in_ch.data.last_part;
            t_r    <= T_XX;
            state_r <= (n_in == '0) ? S_FIN : S_PROD;
          end
        end
        S_PROD: begin
          prod_r  <= product[61:0];
          state_r <= S_UU;
        end
        S_UU: begin
          uu_r    <= product;
          acc_r   <= '0;
          pc_r    <= '0;
          state_r <= S_PP;
        end
        S_PP: begin
          acc_r <= acc_r + (128'(product) << {pw, 5'b0});
          pc_r  <= pc_r + 2'd1;
          if (pc_r == 2'd3) begin
            state_r <= S_DSTART;
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (!div_busy) begin
            state_r <= (t_r == T_MX || t_r == T_MY) ? S_MEAN : S_TERM;
          end
        end
        S_TERM: begin
          unique case (t_r)
            T_XX: begin
              if (sum > $signed(130'(mbm_pkg::M2_MAX))) begin
                acc_m2_x_r     <= mbm_pkg::M2_MAX;
                acc_overflow_r <= 1'b1;
              end else begin
                acc_m2_x_r <= sum[62:0];
              end
              t_r     <= T_YY;
              state_r <= S_UU;
            end
            T_YY: begin
              if (sum > $signed(130'(mbm_pkg::M2_MAX))) begin
                acc_m2_y_r     <= mbm_pkg::M2_MAX;
                acc_overflow_r <= 1'b1;
              end else begin
                acc_m2_y_r <= sum[62:0];
              end
              t_r     <= T_XY;
              state_r <= S_UU;
            end
            default: begin
              if (sum > $signed(130'(mbm_pkg::M2_MAX))) begin
                acc_m_xy_r     <= {1'b0, mbm_pkg::M2_MAX};
                acc_overflow_r <= 1'b1;
              end else if (sum < -$signed(130'({1'b0, mbm_pkg::M2_MAX})) - 130'sd1) begin
                acc_m_xy_r     <= {1'b1, 63'b0};
                acc_overflow_r <= 1'b1;
              end else begin
                acc_m_xy_r <= sum[63:0];
              end
              t_r     <= T_MX;
              state_r <= S_MMUL;
            end
          endcase
        end
        S_MMUL: begin
          acc_r   <= 128'(product);
          state_r <= S_DSTART;
        end
        S_MEAN: begin
          if (t_r == T_MX) begin
            acc_mean_x_r <= mean_new;
            t_r          <= T_MY;
            state_r      <= S_MMUL;
          end else begin
            acc_mean_y_r <= mean_new;
            state_r      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last_r) begin
            acc_count_r    <= cnt_fin;
            acc_overflow_r <= ovf_fin;
            state_r        <= S_IDLE;
          end else if (!out_valid_r || out_ch.ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.total_count <= cnt_fin;
            out_data_r.mean_x      <= acc_mean_x_r;
            out_data_r.mean_y      <= acc_mean_y_r;
            out_data_r.m2_x        <= acc_m2_x_r;
            out_data_r.m2_y        <= acc_m2_y_r;
            out_data_r.m_xy        <= acc_m_xy_r;
            out_data_r.overflow    <= ovf_fin;
            acc_count_r            <= '0;
            acc_mean_x_r           <= '0;
            acc_mean_y_r           <= '0;
            acc_m2_x_r             <= '0;
            acc_m2_y_r             <= '0;
            acc_m_xy_r             <= '0;
            acc_overflow_r         <= 1'b0;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

[design/mbm_checker.sv]
`timescale 1ns / 1ps

module mbm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mbm_pkg::out_item_t out_data
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  // One partial is merged at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a merge is running");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind merge_bivariate_moments_top mbm_checker u_mbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
